### rtl/gdad_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdad_pkg
// Shared types, constants and the month length table for the date adder.
// ----------------------------------------------------------------------------
package gdad_pkg;

  // Width of the day count that is actually used.
  localparam int AddBits = 16;

  localparam int MonthBits = 4;
  localparam int DayBits   = 5;
  localparam int YearBits  = 14;
  localparam int CountBits = 16;
  localparam int StatBits  = 2;

  localparam logic [YearBits-1:0]  MaxYear    = YearBits'(9999);
  localparam logic [MonthBits-1:0] December   = MonthBits'(12);
  localparam logic [MonthBits-1:0] January    = MonthBits'(1);
  localparam logic [DayBits-1:0]   LastDayDec = DayBits'(31);

  // Year reduction modulo 400 by shifted subtraction: 400 << 5 still fits.
  localparam int Cycle400    = 400;
  localparam int RedSteps    = 6;
  localparam int RedCntBits  = $clog2(RedSteps);

  localparam logic [StatBits-1:0] StatusOk       = StatBits'(0);
  localparam logic [StatBits-1:0] StatusInvalid  = StatBits'(1);
  localparam logic [StatBits-1:0] StatusOverflow = StatBits'(2);

  typedef struct packed {
    logic [MonthBits-1:0] month;
    logic [DayBits-1:0]   day;
    logic [YearBits-1:0]  year;
    logic [CountBits-1:0] days_to_add;
  } date_in_t;

  typedef struct packed {
    logic [MonthBits-1:0] new_month;
    logic [DayBits-1:0]   new_day;
    logic [YearBits-1:0]  new_year;
    logic [StatBits-1:0]  status;
  } date_out_t;

  typedef enum logic [2:0] {
    StIdle,
    StReduce,
    StCheck,
    StStep,
    StDone
  } ctrl_state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic                  load;
    logic                  reduce;
    logic [RedCntBits-1:0] red_shift;
    logic                  check;
    logic                  step;
  } gdad_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic date_ok;
    logic left_zero;
  } gdad_sts_t;

  // Days in a month; months outside 1..12 give zero.
  function automatic logic [DayBits-1:0] month_days(input logic [MonthBits-1:0] m,
                                                     input logic leap);
    logic [DayBits-1:0] n;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = DayBits'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    n = DayBits'(30);
      4'd2:                                       n = leap ? DayBits'(29) : DayBits'(28);
      default:                                    n = '0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

### rtl/gdad_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdad_ctrl
// Sequencer: loads an item, reduces the year, checks it, steps month by month.
// ----------------------------------------------------------------------------
module gdad_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire gdad_pkg::gdad_sts_t sts_i,
  output gdad_pkg::gdad_cmd_t     cmd_o,
  output logic                    busy,
  output logic                    done_o
);
  import gdad_pkg::*;

  ctrl_state_e state_q, state_d;
  logic [RedCntBits-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StReduce;
          cnt_d   = RedCntBits'(RedSteps - 1);
        end
      end
      StReduce: begin
        if (cnt_q == '0) begin
          state_d = StCheck;
        end else begin
          cnt_d = cnt_q - RedCntBits'(1);
        end
      end
      StCheck: begin
        state_d = sts_i.date_ok ? StStep : StDone;
      end
      StStep: begin
        if (sts_i.left_zero) begin
          state_d = StDone;
        end
      end
      StDone:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o           = '0;
    cmd_o.red_shift = cnt_q;
    busy            = 1'b1;
    done_o          = 1'b0;
    case (state_q)
      StIdle: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      StReduce: cmd_o.reduce = 1'b1;
      StCheck:  cmd_o.check  = 1'b1;
      StStep:   cmd_o.step   = !sts_i.left_zero;
      StDone:   done_o       = 1'b1;
      default:  busy         = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

### rtl/gdad_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gdad_dp
// Date registers, year-mod-400 tracker and the one-month step unit.
// ----------------------------------------------------------------------------
module gdad_dp (
  input  wire logic                clk_i,
  input  wire gdad_pkg::date_in_t  item_i,
  input  wire gdad_pkg::gdad_cmd_t cmd_i,
  output gdad_pkg::gdad_sts_t      sts_o,
  output gdad_pkg::date_out_t      result_o
);
  import gdad_pkg::*;

  logic [MonthBits-1:0] month_q, month_d;
  logic [DayBits-1:0]   day_q, day_d;
  logic [YearBits-1:0]  year_q, year_d;
  logic [StatBits-1:0]  status_q, status_d;
  logic [AddBits-1:0]   left_q, left_d;
  // Year remainder modulo 400; holds the partial remainder during reduction.
  logic [YearBits-1:0]  rem_q, rem_d;

  logic [YearBits-1:0]  red_sub;
  logic                 leap;
  logic [DayBits-1:0]   mdays;
  logic [DayBits-1:0]   rest;
  logic [AddBits-1:0]   rest_ext;

  always_ff @(posedge clk_i) begin
    month_q  <= month_d;
    day_q    <= day_d;
    year_q   <= year_d;
    status_q <= status_d;
    left_q   <= left_d;
    rem_q    <= rem_d;
  end

  assign red_sub  = YearBits'(Cycle400) << cmd_i.red_shift;
  assign leap     = (year_q[1:0] == 2'b00) && !(rem_q == YearBits'(100) ||
                    rem_q == YearBits'(200) || rem_q == YearBits'(300));
  assign mdays    = month_days(month_q, leap);
  assign rest     = mdays - day_q;
  assign rest_ext = AddBits'(rest);

  assign sts_o.date_ok = (day_q != '0) && (day_q <= mdays) &&
                         (year_q != '0) && (year_q <= MaxYear);
  assign sts_o.left_zero = (left_q == '0);

  always_comb begin
    month_d  = month_q;
    day_d    = day_q;
    year_d   = year_q;
    status_d = status_q;
    left_d   = left_q;
    rem_d    = rem_q;
    if (cmd_i.load) begin
      month_d  = item_i.month;
      day_d    = item_i.day;
      year_d   = item_i.year;
      status_d = StatusOk;
      left_d   = AddBits'(item_i.days_to_add);
      rem_d    = item_i.year;
    end else if (cmd_i.reduce) begin
      if (rem_q >= red_sub) begin
        rem_d = rem_q - red_sub;
      end
    end else if (cmd_i.check) begin
      if (!sts_o.date_ok) begin
        status_d = StatusInvalid;
      end
    end else if (cmd_i.step) begin
      if (left_q > rest_ext) begin
        // Jump to the first of the next month.
        left_d = left_q - rest_ext - AddBits'(1);
        day_d  = DayBits'(1);
        if (month_q == December) begin
          if (year_q == MaxYear) begin
            month_d  = December;
            day_d    = LastDayDec;
            status_d = StatusOverflow;
            left_d   = '0;
          end else begin
            month_d = January;
            year_d  = year_q + YearBits'(1);
            rem_d   = (rem_q == YearBits'(Cycle400 - 1)) ? '0 : rem_q + YearBits'(1);
          end
        end else begin
          month_d = month_q + MonthBits'(1);
        end
      end else begin
        // The rest fits in this month, so left is at most 30 here.
        day_d  = day_q + left_q[DayBits-1:0];
        left_d = '0;
      end
    end
  end

  assign result_o.new_month = month_q;
  assign result_o.new_day   = day_q;
  assign result_o.new_year  = year_q;
  assign result_o.status    = status_q;

endmodule
`default_nettype wire

### rtl/gregorian_date_add_days.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// Adds a day count to a Gregorian date, advancing one month per cycle.
// ----------------------------------------------------------------------------
//
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+--------------------------
// request  | in        | start, busy        | item_i   (date_in_t)
// result   | out       | done_o strobe      | result_o (date_out_t)
//
// An item is taken when start is high and busy is low. The sequencer then
// loads it, reduces the year modulo 400 by shifted subtraction, checks the
// date, steps once per month boundary crossed (up to about 2153 for the
// largest count) plus a final visit to the step state, and ends in the
// result state. When the count ends inside a month, one more step adds
// the remaining days. Invalid dates go from the check straight to the
// result state. Reset is asynchronous and returns the sequencer to idle.
// The result is shown for the one cycle in which done_o is high; the
// receiver cannot hold it off, and busy stays high through that cycle.
//
module gregorian_date_add_days (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire gdad_pkg::date_in_t item_i,
  output logic                    done_o,
  output gdad_pkg::date_out_t     result_o
);
  import gdad_pkg::*;

  gdad_cmd_t cmd;
  gdad_sts_t sts;

  // The sequencer decides what the datapath does in each cycle.
  gdad_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // The datapath holds the working date, the days still to add and the
  // year's remainder modulo 400, which drives the leap-year rule.
  gdad_dp u_dp (
    .clk_i    (clk_i),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .result_o (result_o)
  );

`ifndef ASSERT_OFF
  // An accepted item makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // The result strobe lasts one cycle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  // An overflow always saturates to the last day of year 9999.
  a_overflow_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == StatusOverflow) |->
      (result_o.new_year == MaxYear && result_o.new_month == December &&
       result_o.new_day == LastDayDec))
    else $error("overflow result not saturated");

  // A good result carries a real month and a nonzero day.
  a_ok_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == StatusOk) |->
      (result_o.new_month >= January && result_o.new_month <= December &&
       result_o.new_day != '0))
    else $error("ok result with impossible month or day");
`endif

endmodule
`default_nettype wire
